### rtl/core/poi_pkg.sv
`timescale 1ns / 1ps

package poi_pkg;

    localparam int NUM_WHEELS   = 4;
    localparam int WHEEL_INPUTS = 4;
    localparam int NUM_LANES    = (NUM_WHEELS < WHEEL_INPUTS) ? NUM_WHEELS : WHEEL_INPUTS;
    localparam int CNT_W        = $clog2(NUM_LANES + 1);

    localparam int CORDIC_STEPS = 16;
    localparam int DIV_N_W      = 56;
    localparam int DIV_D_W      = 20;

    localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
    localparam logic [19:0]        US_PER_S     = 20'd1000000;

    localparam logic [2:0] ADDR_YAW = 3'd0;
    localparam logic [2:0] ADDR_MAP = 3'd4;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_SET    = 2'd1,
        CMD_RESET  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_LON  = 2'd1,
        AXIS_LAT  = 2'd2,
        AXIS_SPARE = 2'd3
    } axis_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_ROT,
        S_MUL,
        S_SUM,
        S_VMUL,
        S_VEL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                lon;
        logic                lat;
        logic signed [32:0]  delta;
    } lane_t;

    function automatic logic signed [33:0] atan_entry(input logic [3:0] i);
        logic signed [33:0] r;
        begin
            unique case (i)
                4'd0:  r = 34'sd536870912;
                4'd1:  r = 34'sd316933406;
                4'd2:  r = 34'sd167458907;
                4'd3:  r = 34'sd85004756;
                4'd4:  r = 34'sd42667331;
                4'd5:  r = 34'sd21354465;
                4'd6:  r = 34'sd10679838;
                4'd7:  r = 34'sd5340245;
                4'd8:  r = 34'sd2670163;
                4'd9:  r = 34'sd1335087;
                4'd10: r = 34'sd667544;
                4'd11: r = 34'sd333772;
                4'd12: r = 34'sd166886;
                4'd13: r = 34'sd83443;
                4'd14: r = 34'sd41722;
                4'd15: r = 34'sd20861;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sd2147483647)
                r = 32'sh7FFF_FFFF;
            else if (v < -64'sd2147483648)
                r = 32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

### rtl/core/poi_wheel_lane.sv
`timescale 1ns / 1ps

module poi_wheel_lane (
    input  logic signed [31:0] wheel_pos,
    input  logic signed [31:0] prev,
    input  logic [1:0]         axis,
    output poi_pkg::lane_t     lane
);

    always_comb
    begin
        lane.delta = {wheel_pos[31], wheel_pos} - {prev[31], prev};
        lane.lon   = (axis == poi_pkg::AXIS_LON);
        lane.lat   = (axis == poi_pkg::AXIS_LAT);
    end

endmodule

### rtl/core/poi_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit a cycle, truncates toward zero.
module poi_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [poi_pkg::DIV_N_W-1:0]  dividend,
    input  logic [poi_pkg::DIV_D_W-1:0]         divisor,
    output logic                                done,
    output logic signed [poi_pkg::DIV_N_W:0]    quotient
);

    localparam int CW = $clog2(poi_pkg::DIV_N_W + 1);

    logic                            run_reg;
    logic                            done_reg;
    logic [CW-1:0]                   cnt_reg;
    logic                            neg_reg;
    logic [poi_pkg::DIV_N_W-1:0]     q_reg;
    logic [poi_pkg::DIV_D_W-1:0]     rem_reg;
    logic [poi_pkg::DIV_D_W-1:0]     div_reg;
    logic [poi_pkg::DIV_D_W:0]       trial;
    logic                            fits;
    logic [poi_pkg::DIV_N_W-1:0]     mag;

    assign mag   = dividend[poi_pkg::DIV_N_W-1] ? (~dividend + 1'b1) : dividend;
    assign trial = {rem_reg, q_reg[poi_pkg::DIV_N_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(poi_pkg::DIV_N_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[poi_pkg::DIV_N_W-1];
            q_reg   <= mag;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= poi_pkg::DIV_D_W'(trial - {1'b0, div_reg});
                q_reg   <= {q_reg[poi_pkg::DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[poi_pkg::DIV_D_W-1:0];
                q_reg   <= {q_reg[poi_pkg::DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

### rtl/core/poi_cordic.sv
`timescale 1ns / 1ps

// Iterative rotation-mode CORDIC, one micro-rotation a cycle, signed Q3.30 out.
module poi_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [33:0] cos_q30,
    output logic signed [33:0] sin_q30
);

    logic               run_reg;
    logic               done_reg;
    logic [3:0]         step_reg;
    logic               flip_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic signed [33:0] z0;
    logic signed [33:0] z1;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] at;
    logic               wide;

    always_comb
    begin
        z0   = {{2{angle[31]}}, angle};
        z1   = {{2{~angle[31]}}, ~angle[31], angle[30:0]};
        wide = (z0 > 34'sd1073741824) || (z0 < -34'sd1073741824);
        xs   = x_reg >>> step_reg;
        ys   = y_reg >>> step_reg;
        at   = poi_pkg::atan_entry(step_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 4'(poi_pkg::CORDIC_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= poi_pkg::CORDIC_K_Q30;
            y_reg    <= '0;
            z_reg    <= wide ? z1 : z0;
            flip_reg <= wide;
        end
        else if (run_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done    = done_reg;
    assign cos_q30 = flip_reg ? -x_reg : x_reg;
    assign sin_q30 = flip_reg ? -y_reg : y_reg;

endmodule

### rtl/core/planar_odometry_integrator_core.sv
`timescale 1ns / 1ps

// Sequence: set pose, reset, no-op and baseline samples go from the accepting edge
// straight to S_DONE and then to the output register; a full sample runs a wheel-average
// divide, a 16-step CORDIC, multiply and sum stages, then a velocity divide.
// Flow: one item in flight; the next is taken once the result sits in the output
// register, and out_stall can hold the result, and with it the next item, in S_DONE.
// rst_n clears pose, velocity, baseline, IMU validity and both config registers.
module planar_odometry_integrator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [19:0]        dt_us,
    input  logic               imu_valid,
    input  logic signed [15:0] imu_heading,
    input  logic signed [31:0] wheel_dist_0,
    input  logic signed [31:0] wheel_dist_1,
    input  logic signed [31:0] wheel_dist_2,
    input  logic signed [31:0] wheel_dist_3,
    input  logic signed [31:0] set_x,
    input  logic signed [31:0] set_y,
    input  logic signed [15:0] set_heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pose_x,
    output logic signed [31:0] pose_y,
    output logic signed [15:0] pose_heading,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_turn,
    output logic               baseline_only
);

    localparam int NW = poi_pkg::WHEEL_INPUTS;
    localparam int NL = poi_pkg::NUM_LANES;
    localparam int CW = poi_pkg::CNT_W;
    localparam int NN = poi_pkg::DIV_N_W;

    // configuration
    logic signed [15:0] yaw_offset_reg;
    logic [7:0]         wheel_axis_map_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_offset_reg     <= '0;
            wheel_axis_map_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                poi_pkg::ADDR_YAW: yaw_offset_reg     <= pwdata[15:0];
                poi_pkg::ADDR_MAP: wheel_axis_map_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            poi_pkg::ADDR_YAW: prdata = {16'h0, yaw_offset_reg};
            poi_pkg::ADDR_MAP: prdata = {24'h0, wheel_axis_map_reg};
            default:           prdata = '0;
        endcase
    end

    // estimator state
    poi_pkg::state_t    state_reg, state_next;
    logic               have_base_reg;
    logic               prev_imu_reg;
    logic [15:0]        prev_read_reg;
    logic signed [31:0] prev_wd_reg [NW];
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [15:0]        heading_reg;
    logic signed [31:0] vel_reg [3];
    logic               base_flag_reg;

    // per-item working registers
    logic [CW-1:0]      lcnt_reg, tcnt_reg;
    logic signed [15:0] dth_reg;
    logic [19:0]        dt_reg;
    logic signed [31:0] dxl_reg, dyl_reg;
    logic signed [33:0] c_reg, s_reg;
    logic signed [65:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [34:0] dxw_reg, dyw_reg;

    logic               out_valid_reg;

    logic               accept;
    logic               out_free;
    poi_pkg::cmd_t      cmd;
    logic [15:0]        reading;
    logic               full_sample;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != poi_pkg::S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign cmd      = poi_pkg::cmd_t'(command);
    assign reading  = imu_heading + yaw_offset_reg;
    assign full_sample = (cmd == poi_pkg::CMD_SAMPLE) && have_base_reg;

    // wheel lanes and merge
    logic signed [31:0] wd [NW];
    poi_pkg::lane_t     lanes [NL];
    logic signed [34:0] lsum, tsum;
    logic [CW-1:0]      lcnt, tcnt;

    assign wd[0] = wheel_dist_0;
    assign wd[1] = wheel_dist_1;
    assign wd[2] = wheel_dist_2;
    assign wd[3] = wheel_dist_3;

    for (genvar g = 0; g < NL; g++)
    begin : g_lane
        poi_wheel_lane u_lane (
            .wheel_pos (wd[g]),
            .prev      (prev_wd_reg[g]),
            .axis      (wheel_axis_map_reg[2*g+1:2*g]),
            .lane      (lanes[g])
        );
    end

    always_comb
    begin
        lsum = '0;
        tsum = '0;
        lcnt = '0;
        tcnt = '0;
        for (int i = 0; i < NL; i++)
        begin
            if (lanes[i].lon)
            begin
                lsum = lsum + {{2{lanes[i].delta[32]}}, lanes[i].delta};
                lcnt = lcnt + 1'b1;
            end
            if (lanes[i].lat)
            begin
                tsum = tsum + {{2{lanes[i].delta[32]}}, lanes[i].delta};
                tcnt = tcnt + 1'b1;
            end
        end
    end

    // dividers: lanes 0/1 for the wheel average, all three for velocity
    logic                   div_start [3];
    logic signed [NN-1:0]   div_num   [3];
    logic [19:0]            div_den   [3];
    logic                   div_done  [3];
    logic signed [NN:0]     div_q     [3];
    logic signed [NN-1:0]   vnum      [3];
    logic                   avg_start;
    logic                   vel_start;

    assign avg_start = accept && full_sample;
    assign vel_start = (state_reg == poi_pkg::S_VMUL);

    always_comb
    begin
        vnum[0] = NN'(dxw_reg) * NN'($signed({1'b0, poi_pkg::US_PER_S}));
        vnum[1] = NN'(dyw_reg) * NN'($signed({1'b0, poi_pkg::US_PER_S}));
        vnum[2] = NN'(dth_reg) * NN'($signed({1'b0, poi_pkg::US_PER_S}));
        div_start[0] = avg_start || vel_start;
        div_start[1] = avg_start || vel_start;
        div_start[2] = vel_start;
        if (vel_start)
        begin
            div_num[0] = vnum[0];
            div_num[1] = vnum[1];
            div_den[0] = dt_reg;
            div_den[1] = dt_reg;
        end
        else
        begin
            div_num[0] = NN'(lsum);
            div_num[1] = NN'(tsum);
            div_den[0] = 20'(lcnt);
            div_den[1] = 20'(tcnt);
        end
        div_num[2] = vnum[2];
        div_den[2] = dt_reg;
    end

    for (genvar d = 0; d < 3; d++)
    begin : g_div
        poi_divider u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start[d]),
            .dividend (div_num[d]),
            .divisor  (div_den[d]),
            .done     (div_done[d]),
            .quotient (div_q[d])
        );
    end

    // rotation
    logic               cor_start;
    logic               cor_done;
    logic signed [33:0] cor_c, cor_s;
    logic [31:0]        mid;

    assign mid       = {heading_reg, 16'h0} + {dth_reg[15], dth_reg, 15'h0};
    assign cor_start = (state_reg == poi_pkg::S_AVG) && div_done[0];

    poi_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (mid),
        .done    (cor_done),
        .cos_q30 (cor_c),
        .sin_q30 (cor_s)
    );

    logic signed [66:0] sum_x, sum_y;
    logic signed [34:0] dxw, dyw;

    always_comb
    begin
        sum_x = {pxc_reg[65], pxc_reg} - {pys_reg[65], pys_reg} + 67'sd536870912;
        sum_y = {pxs_reg[65], pxs_reg} + {pyc_reg[65], pyc_reg} + 67'sd536870912;
        dxw   = 35'(sum_x >>> 30);
        dyw   = 35'(sum_y >>> 30);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            poi_pkg::S_IDLE: if (accept) state_next = full_sample ? poi_pkg::S_AVG
                                                                  : poi_pkg::S_DONE;
            poi_pkg::S_AVG:  if (div_done[0]) state_next = poi_pkg::S_ROT;
            poi_pkg::S_ROT:  if (cor_done) state_next = poi_pkg::S_MUL;
            poi_pkg::S_MUL:  state_next = poi_pkg::S_SUM;
            poi_pkg::S_SUM:  state_next = poi_pkg::S_VMUL;
            poi_pkg::S_VMUL: state_next = poi_pkg::S_VEL;
            poi_pkg::S_VEL:  if (div_done[0]) state_next = poi_pkg::S_DONE;
            poi_pkg::S_DONE: if (out_free) state_next = poi_pkg::S_IDLE;
            default:         state_next = poi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= poi_pkg::S_IDLE;
            have_base_reg <= 1'b0;
            prev_imu_reg  <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            for (int i = 0; i < 3; i++)
                vel_reg[i] <= '0;
            base_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                base_flag_reg <= 1'b0;
                unique case (cmd)
                    poi_pkg::CMD_RESET:
                    begin
                        have_base_reg <= 1'b0;
                        prev_imu_reg  <= 1'b0;
                        pos_x_reg     <= '0;
                        pos_y_reg     <= '0;
                        heading_reg   <= '0;
                        for (int i = 0; i < 3; i++)
                            vel_reg[i] <= '0;
                    end
                    poi_pkg::CMD_SET:
                    begin
                        pos_x_reg   <= set_x;
                        pos_y_reg   <= set_y;
                        heading_reg <= set_heading;
                    end
                    poi_pkg::CMD_SAMPLE:
                    begin
                        if (!have_base_reg)
                        begin
                            for (int i = 0; i < 3; i++)
                                vel_reg[i] <= '0;
                            base_flag_reg <= 1'b1;
                        end
                        have_base_reg <= 1'b1;
                        prev_imu_reg  <= imu_valid;
                    end
                    poi_pkg::CMD_NOP: ;
                    default: ;
                endcase
            end

            if (state_reg == poi_pkg::S_SUM)
            begin
                pos_x_reg   <= poi_pkg::sat32(64'(pos_x_reg) + 64'(dxw));
                pos_y_reg   <= poi_pkg::sat32(64'(pos_y_reg) + 64'(dyw));
                heading_reg <= heading_reg + dth_reg;
            end

            if ((state_reg == poi_pkg::S_VEL) && div_done[0])
            begin
                for (int i = 0; i < 3; i++)
                    vel_reg[i] <= (dt_reg == '0) ? 32'sd0 : poi_pkg::sat32(64'(div_q[i]));
            end

            if ((state_reg == poi_pkg::S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && (cmd == poi_pkg::CMD_SAMPLE))
        begin
            for (int i = 0; i < NW; i++)
                prev_wd_reg[i] <= wd[i];
            if (imu_valid)
                prev_read_reg <= reading;
            lcnt_reg <= lcnt;
            tcnt_reg <= tcnt;
            dt_reg   <= dt_us;
            dth_reg  <= (imu_valid && prev_imu_reg) ? $signed(reading - prev_read_reg) : 16'sd0;
        end

        if ((state_reg == poi_pkg::S_AVG) && div_done[0])
        begin
            dxl_reg <= (lcnt_reg == '0) ? 32'sd0 : poi_pkg::sat32(64'(div_q[0]));
            dyl_reg <= (tcnt_reg == '0) ? 32'sd0 : poi_pkg::sat32(64'(div_q[1]));
        end

        if (cor_done)
        begin
            c_reg <= cor_c;
            s_reg <= cor_s;
        end

        if (state_reg == poi_pkg::S_MUL)
        begin
            pxc_reg <= dxl_reg * c_reg;
            pys_reg <= dyl_reg * s_reg;
            pxs_reg <= dxl_reg * s_reg;
            pyc_reg <= dyl_reg * c_reg;
        end

        if (state_reg == poi_pkg::S_SUM)
        begin
            dxw_reg <= dxw;
            dyw_reg <= dyw;
        end

        if ((state_reg == poi_pkg::S_DONE) && out_free)
        begin
            pose_x        <= pos_x_reg;
            pose_y        <= pos_y_reg;
            pose_heading  <= heading_reg;
            vel_x         <= vel_reg[0];
            vel_y         <= vel_reg[1];
            vel_turn      <= vel_reg[2];
            baseline_only <= base_flag_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
